// ----- rtl/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types for the closest-point-on-triangle pipeline: word layouts of
// both channels and the region codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  localparam int unsigned CoordBits = 32;

  typedef enum logic [2:0] {
    RGN_A     = 3'd0,
    RGN_B     = 3'd1,
    RGN_AB    = 3'd2,
    RGN_C     = 3'd3,
    RGN_AC    = 3'd4,
    RGN_BC    = 3'd5,
    RGN_INT   = 3'd6,
    RGN_DEGEN = 3'd7
  } region_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
    logic signed [CoordBits-1:0] query_z;
    logic signed [CoordBits-1:0] vert_a_x;
    logic signed [CoordBits-1:0] vert_a_y;
    logic signed [CoordBits-1:0] vert_a_z;
    logic signed [CoordBits-1:0] vert_b_x;
    logic signed [CoordBits-1:0] vert_b_y;
    logic signed [CoordBits-1:0] vert_b_z;
    logic signed [CoordBits-1:0] vert_c_x;
    logic signed [CoordBits-1:0] vert_c_y;
    logic signed [CoordBits-1:0] vert_c_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] near_x;
    logic signed [CoordBits-1:0] near_y;
    logic signed [CoordBits-1:0] near_z;
    logic [2:0]                  region;
  } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/cpt_stream_if.sv -----
// ----------------------------------------------------------------------------
// cpt_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/closest_point_on_triangle_top.sv -----
// ----------------------------------------------------------------------------
// closest_point_on_triangle_top
// Nearest point on triangle abc to query p by the Voronoi region tests, with
// the region code. Fully pipelined, no state between words.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           word
//  in_i     in   in_i.valid/ready    query point, vertices a b c (Q16.16)
//  out_o    out  out_o.valid/ready   nearest point, region code
//
//  one word per cycle while the output is not stalled
//  the fraction divider, one quotient bit per stage, sets most of the depth
//  each stage advances when it is empty or the stage after it advances, so
//  bubbles close up and a stalled output still lets earlier stages fill
//  reset clears only the valid bits of the stages
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_triangle_top
  import cpt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpt_stream_if.sink   in_i,
  cpt_stream_if.source out_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned EW  = W + 1;
  localparam int unsigned DW  = 2 * EW + 2;
  localparam int unsigned EDW = DW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned VW  = PW + 1;
  localparam int unsigned NW  = PW + 3;
  localparam int unsigned BW  = EW + F + 2;
  localparam int unsigned SW  = BW + 1;
  localparam int unsigned RW  = SW - F + 1;

  localparam int unsigned ST_DIFF  = 0;
  localparam int unsigned ST_PROD  = 1;
  localparam int unsigned ST_DOT   = 2;
  localparam int unsigned ST_M0    = 3;
  localparam int unsigned ST_M2    = 5;
  localparam int unsigned ST_VABC  = 6;
  localparam int unsigned ST_SEL   = 7;
  localparam int unsigned ST_FIX   = 8;
  localparam int unsigned ST_DIV0  = 9;
  localparam int unsigned ST_BLEND = ST_DIV0 + F + 1;
  localparam int unsigned ST_OUT   = ST_BLEND + 1;
  localparam int unsigned NS       = ST_OUT + 1;
  localparam int unsigned GEO_LAST = ST_BLEND - 1;

  localparam int unsigned G_A  = 0;
  localparam int unsigned G_B  = 1;
  localparam int unsigned G_C  = 2;
  localparam int unsigned G_AB = 3;
  localparam int unsigned G_AC = 4;
  localparam int unsigned G_BC = 5;

  // operand pairs of va, vb, vc products
  localparam int unsigned MulX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int unsigned MulY [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct packed {
    logic at_a;
    logic at_b;
    logic ab_side;
    logic at_c;
    logic ac_side;
    logic bc_side;
  } vflags_t;

  // ---------------- stage control ----------------
  logic [NS-1:0] vld_q, vld_d, en;

  assign en[NS-1] = ~vld_q[NS-1] | out_o.ready;
  for (genvar s = 0; s < NS - 1; s++) begin : g_en
    assign en[s] = ~vld_q[s] | en[s+1];
  end

  assign vld_d = (vld_q & ~en) | ({vld_q[NS-2:0], in_i.valid} & en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = vld_q[NS-1];

  // ---------------- differences ----------------
  logic signed [W-1:0]  p_c [3], a_c [3], b_c [3], c_c [3];
  logic signed [EW-1:0] geo_q [ST_DIFF:GEO_LAST][6][3];
  logic signed [EW-1:0] ap_q [3], bp_q [3], cp_q [3];

  assign p_c[0] = in_i.payload.query_x[W-1:0];
  assign p_c[1] = in_i.payload.query_y[W-1:0];
  assign p_c[2] = in_i.payload.query_z[W-1:0];
  assign a_c[0] = in_i.payload.vert_a_x[W-1:0];
  assign a_c[1] = in_i.payload.vert_a_y[W-1:0];
  assign a_c[2] = in_i.payload.vert_a_z[W-1:0];
  assign b_c[0] = in_i.payload.vert_b_x[W-1:0];
  assign b_c[1] = in_i.payload.vert_b_y[W-1:0];
  assign b_c[2] = in_i.payload.vert_b_z[W-1:0];
  assign c_c[0] = in_i.payload.vert_c_x[W-1:0];
  assign c_c[1] = in_i.payload.vert_c_y[W-1:0];
  assign c_c[2] = in_i.payload.vert_c_z[W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[ST_DIFF]) begin
      for (int k = 0; k < 3; k++) begin
        geo_q[ST_DIFF][G_A][k]  <= EW'(a_c[k]);
        geo_q[ST_DIFF][G_B][k]  <= EW'(b_c[k]);
        geo_q[ST_DIFF][G_C][k]  <= EW'(c_c[k]);
        geo_q[ST_DIFF][G_AB][k] <= EW'(b_c[k]) - EW'(a_c[k]);
        geo_q[ST_DIFF][G_AC][k] <= EW'(c_c[k]) - EW'(a_c[k]);
        geo_q[ST_DIFF][G_BC][k] <= EW'(c_c[k]) - EW'(b_c[k]);
        ap_q[k] <= EW'(p_c[k]) - EW'(a_c[k]);
        bp_q[k] <= EW'(p_c[k]) - EW'(b_c[k]);
        cp_q[k] <= EW'(p_c[k]) - EW'(c_c[k]);
      end
    end
  end

  for (genvar s = ST_DIFF + 1; s <= GEO_LAST; s++) begin : g_geo
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        geo_q[s] <= geo_q[s-1];
      end
    end
  end

  // ---------------- dot products ----------------
  logic signed [DW-1:0] d_dot [6];

  cpt_dot #(.EW(EW)) u_cpt_dot (
    .clk_i (clk_i),
    .en_i  (en[ST_DOT:ST_PROD]),
    .ab_i  (geo_q[ST_DIFF][G_AB]),
    .ac_i  (geo_q[ST_DIFF][G_AC]),
    .ap_i  (ap_q),
    .bp_i  (bp_q),
    .cp_i  (cp_q),
    .d_o   (d_dot)
  );

  // ---------------- va, vb, vc products ----------------
  logic signed [DW-1:0] dcar_q [ST_M0:ST_M2][6];
  logic signed [PW-1:0] vprod [6];

  for (genvar s = ST_M0; s <= ST_M2; s++) begin : g_dcar
    if (s == ST_M0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          dcar_q[s] <= d_dot;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          dcar_q[s] <= dcar_q[s-1];
        end
      end
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_mul
    cpt_wmul #(.DW(DW)) u_cpt_wmul (
      .clk_i (clk_i),
      .en_i  (en[ST_M2:ST_M0]),
      .a_i   (d_dot[MulX[g]]),
      .b_i   (d_dot[MulY[g]]),
      .p_o   (vprod[g])
    );
  end

  // ---------------- region values and side tests ----------------
  logic signed [DW-1:0]  dc [6];
  logic signed [EDW-1:0] d34, d65;
  logic signed [VW-1:0]  va_q, vb_q, vc_q;
  logic signed [EDW-1:0] e1_q, e2_q, n1_q, n2_q;
  logic signed [DW-1:0]  d1_q, d2_q;
  vflags_t               vf_d, vf_q;
  logic signed [EDW-1:0] n1_d, n2_d;

  assign dc   = dcar_q[ST_M2];
  assign d34  = EDW'(dc[2]) - EDW'(dc[3]);
  assign d65  = EDW'(dc[5]) - EDW'(dc[4]);
  assign n1_d = EDW'(dc[3]) - EDW'(dc[2]);
  assign n2_d = EDW'(dc[4]) - EDW'(dc[5]);

  always_comb begin
    vf_d.at_a    = (dc[0][DW-1] || dc[0] == '0) && (dc[1][DW-1] || dc[1] == '0);
    vf_d.at_b    = !dc[2][DW-1] && !d34[EDW-1];
    vf_d.ab_side = !dc[0][DW-1] && (dc[2][DW-1] || dc[2] == '0);
    vf_d.at_c    = !dc[5][DW-1] && !d65[EDW-1];
    vf_d.ac_side = !dc[1][DW-1] && (dc[5][DW-1] || dc[5] == '0);
    vf_d.bc_side = !n1_d[EDW-1] && !n2_d[EDW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_VABC]) begin
      vc_q <= VW'(vprod[0]) - VW'(vprod[1]);
      vb_q <= VW'(vprod[2]) - VW'(vprod[3]);
      va_q <= VW'(vprod[4]) - VW'(vprod[5]);
      e1_q <= EDW'(dc[0]) - EDW'(dc[2]);
      e2_q <= EDW'(dc[1]) - EDW'(dc[5]);
      n1_q <= n1_d;
      n2_q <= n2_d;
      d1_q <= dc[0];
      d2_q <= dc[1];
      vf_q <= vf_d;
    end
  end

  // ---------------- region select, divider operands ----------------
  region_e              rgn_q [ST_SEL:ST_BLEND-1];
  region_e              rgn_d;
  logic signed [NW-1:0] sum3, num0_d, num1_d, den_d;
  logic signed [NW-1:0] sel_num0_q, sel_num1_q, sel_den_q;
  logic                 va_le0, vb_le0, vc_le0;

  assign va_le0 = va_q[VW-1] || va_q == '0;
  assign vb_le0 = vb_q[VW-1] || vb_q == '0;
  assign vc_le0 = vc_q[VW-1] || vc_q == '0;
  assign sum3   = NW'(va_q) + NW'(vb_q) + NW'(vc_q);

  always_comb begin
    priority if (vf_q.at_a) begin
      rgn_d = RGN_A;
    end else if (vf_q.at_b) begin
      rgn_d = RGN_B;
    end else if (vc_le0 && vf_q.ab_side) begin
      rgn_d = RGN_AB;
    end else if (vf_q.at_c) begin
      rgn_d = RGN_C;
    end else if (vb_le0 && vf_q.ac_side) begin
      rgn_d = RGN_AC;
    end else if (va_le0 && vf_q.bc_side) begin
      rgn_d = RGN_BC;
    end else begin
      rgn_d = RGN_INT;
    end
  end

  always_comb begin
    num0_d = '0;
    num1_d = '0;
    den_d  = '0;
    unique case (rgn_d)
      RGN_AB: begin
        num0_d = NW'(d1_q);
        den_d  = NW'(e1_q);
      end
      RGN_AC: begin
        num0_d = NW'(d2_q);
        den_d  = NW'(e2_q);
      end
      RGN_BC: begin
        num0_d = NW'(n1_q);
        den_d  = NW'(n1_q) + NW'(n2_q);
      end
      RGN_INT: begin
        num0_d = NW'(vb_q);
        num1_d = NW'(vc_q);
        den_d  = sum3;
      end
      default: begin
        num0_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SEL]) begin
      sel_num0_q    <= num0_d;
      sel_num1_q    <= num1_d;
      sel_den_q     <= den_d;
      rgn_q[ST_SEL] <= rgn_d;
    end
  end

  // ---------------- zero and sign fix of the divisor ----------------
  logic signed [NW-1:0] fix_num0_q, fix_num1_q, fix_den_q;
  logic                 divides;

  assign divides = rgn_q[ST_SEL] == RGN_AB || rgn_q[ST_SEL] == RGN_AC ||
                   rgn_q[ST_SEL] == RGN_BC || rgn_q[ST_SEL] == RGN_INT;

  always_ff @(posedge clk_i) begin
    if (en[ST_FIX]) begin
      rgn_q[ST_FIX] <= (divides && sel_den_q == '0) ? RGN_DEGEN : rgn_q[ST_SEL];
      if (sel_den_q[NW-1]) begin
        fix_num0_q <= -sel_num0_q;
        fix_num1_q <= -sel_num1_q;
        fix_den_q  <= -sel_den_q;
      end else begin
        fix_num0_q <= sel_num0_q;
        fix_num1_q <= sel_num1_q;
        fix_den_q  <= sel_den_q;
      end
    end
  end

  for (genvar s = ST_DIV0; s <= ST_BLEND - 1; s++) begin : g_rgn
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rgn_q[s] <= rgn_q[s-1];
      end
    end
  end

  // ---------------- dividers ----------------
  logic [F:0] frac0, frac1;

  cpt_div #(.NW(NW), .FB(F)) u_cpt_div0 (
    .clk_i  (clk_i),
    .en_i   (en[ST_DIV0+F:ST_DIV0]),
    .num_i  (fix_num0_q),
    .den_i  (fix_den_q),
    .frac_o (frac0)
  );

  cpt_div #(.NW(NW), .FB(F)) u_cpt_div1 (
    .clk_i  (clk_i),
    .en_i   (en[ST_DIV0+F:ST_DIV0]),
    .num_i  (fix_num1_q),
    .den_i  (fix_den_q),
    .frac_o (frac1)
  );

  // ---------------- blend weights ----------------
  logic signed [EW-1:0] base_d [3], edge0_d [3], edge1_d [3];
  logic [F:0]           wt0_d, wt1_d;
  logic signed [BW-1:0] bl_m0_q [3], bl_m1_q [3];
  logic signed [EW-1:0] bl_base_q [3];
  region_e              bl_rgn_q;
  region_e              rgn_b;

  assign rgn_b = rgn_q[ST_BLEND-1];

  always_comb begin
    base_d  = geo_q[GEO_LAST][G_A];
    edge0_d = '{default: '0};
    edge1_d = '{default: '0};
    wt0_d   = frac0;
    wt1_d   = frac1;
    unique case (rgn_b)
      RGN_B:   base_d = geo_q[GEO_LAST][G_B];
      RGN_C:   base_d = geo_q[GEO_LAST][G_C];
      RGN_AB:  edge0_d = geo_q[GEO_LAST][G_AB];
      RGN_AC:  edge0_d = geo_q[GEO_LAST][G_AC];
      RGN_BC: begin
        base_d  = geo_q[GEO_LAST][G_B];
        edge0_d = geo_q[GEO_LAST][G_BC];
      end
      RGN_INT: begin
        edge0_d = geo_q[GEO_LAST][G_AB];
        edge1_d = geo_q[GEO_LAST][G_AC];
      end
      default: base_d = geo_q[GEO_LAST][G_A];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_BLEND]) begin
      for (int k = 0; k < 3; k++) begin
        bl_m0_q[k]   <= edge0_d[k] * $signed({1'b0, wt0_d});
        bl_m1_q[k]   <= edge1_d[k] * $signed({1'b0, wt1_d});
        bl_base_q[k] <= base_d[k];
      end
      bl_rgn_q <= rgn_b;
    end
  end

  // ---------------- scale, offset, saturate ----------------
  logic signed [SW-1:0] bsum [3];
  logic signed [RW-1:0] bres [3];
  logic signed [W-1:0]  bsat [3];
  out_word_t            out_d, out_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bsum[k] = SW'(bl_m0_q[k]) + SW'(bl_m1_q[k]);
      // arithmetic shift floors toward minus infinity
      bres[k] = RW'($signed(bsum[k][SW-1:F])) + RW'(bl_base_q[k]);
      if (bres[k][RW-1:W-1] == '0 || bres[k][RW-1:W-1] == '1) begin
        bsat[k] = bres[k][W-1:0];
      end else if (bres[k][RW-1]) begin
        bsat[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        bsat[k] = {1'b0, {(W-1){1'b1}}};
      end
    end
    out_d.near_x = CoordBits'(bsat[0]);
    out_d.near_y = CoordBits'(bsat[1]);
    out_d.near_z = CoordBits'(bsat[2]);
    out_d.region = bl_rgn_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign out_o.payload = out_q;

endmodule

`default_nettype wire

// ----- rtl/cpt_dot.sv -----
// ----------------------------------------------------------------------------
// cpt_dot
// Two-stage dot product unit: eighteen narrow products, then the six sums
// d1..d6 of the region tests.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_dot #(
  parameter int unsigned EW = 33
) (
  input  logic                       clk_i,
  input  logic [1:0]                 en_i,
  input  logic signed [EW-1:0]       ab_i [3],
  input  logic signed [EW-1:0]       ac_i [3],
  input  logic signed [EW-1:0]       ap_i [3],
  input  logic signed [EW-1:0]       bp_i [3],
  input  logic signed [EW-1:0]       cp_i [3],
  output logic signed [2*EW+1:0]     d_o  [6]
);

  localparam int unsigned PRW = 2 * EW;
  localparam int unsigned DW  = PRW + 2;

  logic signed [EW-1:0]  lhs [6][3];
  logic signed [EW-1:0]  rhs [6][3];
  logic signed [PRW-1:0] prod_q [6][3];
  logic signed [DW-1:0]  d_q [6];

  // d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
  always_comb begin
    lhs[0] = ab_i; rhs[0] = ap_i;
    lhs[1] = ac_i; rhs[1] = ap_i;
    lhs[2] = ab_i; rhs[2] = bp_i;
    lhs[3] = ac_i; rhs[3] = bp_i;
    lhs[4] = ab_i; rhs[4] = cp_i;
    lhs[5] = ac_i; rhs[5] = cp_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int j = 0; j < 6; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[j][k] <= lhs[j][k] * rhs[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int j = 0; j < 6; j++) begin
        d_q[j] <= DW'(prod_q[j][0]) + DW'(prod_q[j][1]) + DW'(prod_q[j][2]);
      end
    end
  end

  assign d_o = d_q;

endmodule

`default_nettype wire

// ----- rtl/cpt_wmul.sv -----
// ----------------------------------------------------------------------------
// cpt_wmul
// Three-stage signed wide multiplier built from four half-width partial
// products: partials, then top/cross merge, then final add.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_wmul #(
  parameter int unsigned DW = 68
) (
  input  logic                    clk_i,
  input  logic [2:0]              en_i,
  input  logic signed [DW-1:0]    a_i,
  input  logic signed [DW-1:0]    b_i,
  output logic signed [2*DW-1:0]  p_o
);

  localparam int unsigned K  = DW / 2;
  localparam int unsigned HW = DW - K;
  localparam int unsigned CW = HW + K + 2;
  localparam int unsigned PW = 2 * DW;

  logic signed [HW-1:0]   ah, bh;
  logic [K-1:0]           al, bl;
  logic signed [2*HW-1:0] hh_q;
  logic signed [HW+K:0]   hl_q, lh_q;
  logic [2*K-1:0]         ll_q;
  logic signed [PW-1:0]   top_q;
  logic signed [CW-1:0]   cross_q;
  logic signed [PW-1:0]   p_q;

  assign ah = a_i[DW-1:K];
  assign bh = b_i[DW-1:K];
  assign al = a_i[K-1:0];
  assign bl = b_i[K-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hh_q <= ah * bh;
      hl_q <= ah * $signed({1'b0, bl});
      lh_q <= $signed({1'b0, al}) * bh;
      ll_q <= al * bl;
    end
  end

  // low partial is unsigned and below 2^2K, so high and low just abut
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      top_q   <= $signed({hh_q, ll_q});
      cross_q <= CW'(hl_q) + CW'(lh_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p_q <= top_q + (PW'(cross_q) <<< K);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- rtl/cpt_div.sv -----
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined fraction divider: floor(num * 2^FB / den) clamped to [0, 2^FB],
// one quotient bit per stage after an entry stage that sorts out the clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_div #(
  parameter int unsigned NW = 139,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic [FB:0]          en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [NW-1:0] den_i,
  output logic [FB:0]          frac_o
);

  localparam logic [1:0] ModeCalc = 2'd0;
  localparam logic [1:0] ModeZero = 2'd1;
  localparam logic [1:0] ModeOne  = 2'd2;

  logic [1:0]    mode_q [FB+1];
  logic [NW-1:0] rem_q  [FB+1];
  logic [NW-1:0] den_q  [FB+1];
  logic [FB-1:0] quo_q  [FB+1];
  logic [1:0]    mode_d;

  always_comb begin
    if (num_i[NW-1] || num_i == '0) begin
      mode_d = ModeZero;
    end else if (num_i >= den_i) begin
      mode_d = ModeOne;
    end else begin
      mode_d = ModeCalc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mode_q[0] <= mode_d;
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [NW:0] dbl, dif;
    assign dbl = {rem_q[k-1], 1'b0};
    assign dif = dbl - {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        mode_q[k] <= mode_q[k-1];
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= {quo_q[k-1][FB-2:0], ~dif[NW]};
        rem_q[k]  <= dif[NW] ? dbl[NW-1:0] : dif[NW-1:0];
      end
    end
  end

  always_comb begin
    unique case (mode_q[FB])
      ModeOne:  frac_o = {1'b1, {FB{1'b0}}};
      ModeZero: frac_o = '0;
      default:  frac_o = {1'b0, quo_q[FB]};
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/cpt_checker.sv -----
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks of the closest-point pipeline: occupancy, stall
// behavior and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_checker
  import cpt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_word_i
);

  localparam int unsigned Depth = FRAC_BITS + 12;
  localparam int unsigned CntW  = $clog2(Depth + 2);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cnt_d   = cnt_q + CntW'(in_acc) - CntW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // words in flight never exceed the number of stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("more words in flight than pipeline stages");

  // no word appears without one having gone in
  a_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("output word with nothing in flight");

  // a free output always frees the input
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output is taken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled output word changed or dropped");

  // checked through the non-overlapping implication, so reset has already cleared the stages
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind closest_point_on_triangle_top cpt_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_cpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.payload)
);

`default_nettype wire
